// ===== src/rte_pkg.sv =====
package rte_pkg;

   localparam logic [7:0] MARK_MASK = 8'h80;
   localparam logic [7:0] LOW_MASK  = 8'h7F;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;
   localparam int unsigned MAX_RES = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       blk_end;
   } entry_type;

endpackage

// ===== src/rle_text_encoder.sv =====
// latency: the first result byte of an accepted beat is offered on the next cycle when the
//   result queue is empty, else after the bytes already waiting ahead of it
// input throughput: one beat per cycle while each beat yields at most one byte and the
//   result side does not stall
// output: one byte per cycle from a 4-entry result queue while rsp_stall is low; a beat is
//   taken while the queue holds at most one byte, so its up to three bytes always fit
// reset: synchronous, clears the held run and empties the result queue
module rle_text_encoder #(
   parameter int unsigned MAX_RUN = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_block_end
);
   import rte_pkg::*;

   localparam logic [7:0] MaxRun = 8'(MAX_RUN);

   logic [7:0]          held_ff, held_in;
   logic [7:0]          run_ff, run_in;
   entry_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [QPTR_W-1:0]   wr_idx;

   entry_type           res [MAX_RES];
   logic [1:0]          res_cnt;
   logic                accept;
   logic                pop;
   logic                hit;

   assign req_stall = cnt_ff > QCNT_W'(1);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = cnt_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_idx    = rd_ff + cnt_ff[QPTR_W-1:0];

   assign rsp_out_byte  = q_ff[rd_ff].data;
   assign rsp_out_last  = q_ff[rd_ff].last;
   assign rsp_block_end = q_ff[rd_ff].blk_end;

   assign hit = (run_ff != '0) && (req_in_byte == held_ff) && (run_ff < MaxRun);

   // build the result list of one beat in stream order
   always_comb begin
      logic [1:0] idx;
      idx     = '0;
      res[0]  = '0;
      res[1]  = '0;
      res[2]  = '0;
      held_in = held_ff;
      run_in  = run_ff;
      if (hit) begin
         run_in = run_ff + 8'd1;
      end else begin
         if (run_ff == 8'd1) begin
            res[idx].data = held_ff & LOW_MASK;
            idx = idx + 2'd1;
         end else if (run_ff >= 8'd2) begin
            res[idx].data = held_ff | MARK_MASK;
            idx = idx + 2'd1;
            res[idx].data = run_ff;
            idx = idx + 2'd1;
         end
         held_in = '0;
         run_in  = '0;
         if (!req_in_byte[7]) begin
            held_in = req_in_byte;
            run_in  = 8'd1;
         end else begin
            res[idx].data = req_in_byte & LOW_MASK;
            idx = idx + 2'd1;
         end
      end
      // end of block flushes whatever is held now
      if (req_in_end) begin
         if (run_in == 8'd1) begin
            res[idx].data = held_in & LOW_MASK;
            idx = idx + 2'd1;
         end else if (run_in >= 8'd2) begin
            res[idx].data = held_in | MARK_MASK;
            idx = idx + 2'd1;
            res[idx].data = run_in;
            idx = idx + 2'd1;
         end
         held_in = '0;
         run_in  = '0;
      end
      if (idx != '0) begin
         res[idx - 2'd1].last    = 1'b1;
         res[idx - 2'd1].blk_end = req_in_end;
      end
      res_cnt = idx;
   end

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (accept) begin
         cnt_in = cnt_in + QCNT_W'(res_cnt);
      end
      if (pop) begin
         cnt_in = cnt_in - QCNT_W'(1);
         rd_in  = rd_ff + QPTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         run_ff  <= '0;
         rd_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         if (accept) begin
            held_ff <= held_in;
            run_ff  <= run_in;
         end
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < res_cnt) begin
               q_ff[wr_idx + QPTR_W'(i)] <= res[i];
            end
         end
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");

   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      run_ff <= MaxRun)
      else $error("run length beyond cap");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_end |=> run_ff == '0 && held_ff == '0)
      else $error("run state not cleared after block end");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_out_last)
      else $error("block end on a byte that is not last of its beat");

endmodule

// ===== tb/sv/rle_text_encoder_test.sv =====
module rle_text_encoder_test;
   import rte_pkg::*;

   localparam int unsigned RUN_LIMIT   = 255;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_BEATS = 210;
   localparam int unsigned CALM_TAIL   = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;
   } beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_block_end;

   beat_type   pending_beats[$];
   entry_type  expected_bytes[$];
   entry_type  beat_out[3];
   int         beat_n;
   logic [7:0] run_byte;
   logic [7:0] run_count;
   int         send_gap;
   int         stall_left;
   int         fail_count = 0;
   int         cycle_count = 0;
   bit         calm;

   rle_text_encoder #(
      .MAX_RUN(RUN_LIMIT)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_end   (req_in_end),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_block_end(rsp_block_end)
   );

   always #4 clock = ~clock;

   // predictor of the encoded byte stream
   task automatic put_byte(input logic [7:0] b);
      beat_out[beat_n].data    = b;
      beat_out[beat_n].last    = 1'b0;
      beat_out[beat_n].blk_end = 1'b0;
      beat_n++;
   endtask

   task automatic close_run();
      if (run_count == 8'd1) begin
         put_byte(run_byte & LOW_MASK);
      end else if (run_count >= 8'd2) begin
         put_byte(run_byte | MARK_MASK);
         put_byte(run_count);
      end
      run_count = 8'd0;
      run_byte  = 8'd0;
   endtask

   task automatic encode_beat(input logic [7:0] b, input logic e);
      beat_n = 0;
      if (run_count != 8'd0 && b == run_byte && run_count < RUN_LIMIT[7:0]) begin
         run_count = run_count + 8'd1;
      end else begin
         close_run();
         if (!b[7]) begin
            run_byte  = b;
            run_count = 8'd1;
         end else begin
            put_byte(b & LOW_MASK);
         end
      end
      if (e) close_run();
      if (beat_n > 0) begin
         beat_out[beat_n - 1].last    = 1'b1;
         beat_out[beat_n - 1].blk_end = e;
      end
      for (int i = 0; i < beat_n; i++) expected_bytes.push_back(beat_out[i]);
   endtask

   task automatic add_run(input logic [7:0] b, input int len, input bit close,
                          input bit drain);
      beat_type bt;
      for (int i = 0; i < len; i++) begin
         bt.data  = b;
         bt.last  = close && (i == len - 1);
         bt.drain = drain && (i == 0);
         pending_beats.push_back(bt);
      end
   endtask

   // driver
   always @(posedge clock) begin : drive
      beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         run_byte  = 8'd0;
         run_count = 8'd0;
         send_gap  = 0;
      end else begin
         if (req_valid && !req_stall) encode_beat(req_in_byte, req_in_end);
         calm = pending_beats.size() < CALM_TAIL;
         if (req_valid && req_stall) begin
            // stalled beat holds its payload
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() == 0 ||
                      (pending_beats[0].drain && expected_bytes.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_valid <= 1'b0;
         end else begin
            nxt = pending_beats.pop_front();
            req_valid   <= 1'b1;
            req_in_byte <= nxt.data;
            req_in_end  <= nxt.last;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      entry_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result beat: out_byte %02h", rsp_out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_last !== want.last) begin
                  $error("out_last: expected %0b, got %0b", want.last, rsp_out_last);
                  fail_count++;
               end
               if (rsp_block_end !== want.blk_end) begin
                  $error("block_end: expected %0b, got %0b", want.blk_end, rsp_block_end);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int         made;
      int         nruns;
      int         len;
      int         kind;
      logic [7:0] b;
      logic [7:0] prev_b;
      bit         first;
      bit         close;

      // zero run right after reset, when the held byte is also zero
      add_run(8'h00, 3, 1'b1, 1'b0);
      add_run("A", 1, 1'b1, 1'b0);
      // run, then a literal that also closes the block: three bytes from one beat
      add_run("b", 3, 1'b0, 1'b0);
      add_run("c", 1, 1'b1, 1'b0);
      add_run(8'hFF, 1, 1'b0, 1'b0);
      add_run(8'h80, 1, 1'b1, 1'b0);
      add_run("x", 1, 1'b0, 1'b0);
      add_run(8'hC1, 1, 1'b0, 1'b0);
      add_run(8'h7F, 2, 1'b1, 1'b0);
      // high bytes repeat without being run-coded
      add_run(8'hAA, 3, 1'b0, 1'b0);
      add_run("q", 2, 1'b0, 1'b0);
      add_run(8'hE5, 1, 1'b1, 1'b0);
      // equal bytes on both sides of a block boundary stay apart
      add_run("m", 1, 1'b1, 1'b0);
      add_run("m", 1, 1'b1, 1'b0);
      add_run(8'h01, 1, 1'b0, 1'b0);
      add_run(8'h40, 2, 1'b1, 1'b0);
      // run of 256: the cap is reached one beat before the last, which starts a new run and ends the block
      add_run("z", 256, 1'b1, 1'b1);
      add_run("z", 1, 1'b0, 1'b0);
      add_run(8'h55, 1, 1'b1, 1'b0);

      made   = 0;
      first  = 1'b1;
      prev_b = 8'h00;
      while (made < RANDOM_BEATS) begin
         if ($urandom_range(0, 11) == 0) begin
            // noise beat
            add_run(8'($urandom_range(0, 255)), 1, 1'($urandom_range(0, 1)), 1'b0);
            made++;
         end else begin
            nruns = $urandom_range(1, 6);
            // a broken block carries on without its end beat
            close = $urandom_range(0, 7) != 0;
            for (int r = 0; r < nruns; r++) begin
               kind = $urandom_range(0, 9);
               if (kind < 6)      b = 8'($urandom_range(0, 127));
               else if (kind < 8) b = prev_b;
               else               b = 8'($urandom_range(128, 255));
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                 : $urandom_range(1, 4);
               add_run(b, len, close && (r == nruns - 1),
                       (r == 0) && (first || $urandom_range(0, 9) == 0));
               first  = 1'b0;
               prev_b = b;
               made += len;
            end
         end
      end
      add_run(8'h3C, 2, 1'b1, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== rle_text_encoder.f =====
src/rte_pkg.sv
src/rle_text_encoder.sv
tb/sv/rle_text_encoder_test.sv
